// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the run-length bitset decoder modules.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBD_CHECK(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define RBD_CHECK_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RBD_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RBD_CHECK(lbl, clk, rst, cond, msg)
`define RBD_CHECK_IMPL(lbl, clk, rst, ante, cons, msg)
`define RBD_CHECK_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/rbd_pkg.sv =====
// Types, codes and constants of the run-length bitset record decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rbd_pkg;

  localparam int TRI_COUNT_BITS_DEF = 24;
  localparam int OUT_DEPTH          = 4;
  localparam int CFG_IDX_W          = 2;
  localparam int TRI_W              = 25;
  localparam int NW_W               = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_TRI_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_PRESENT = 2'd1;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_ID    = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_LONG_VARINT  = 3'd1,
    ERR_ZERO_RUN     = 3'd2,
    ERR_RUN_OVERFLOW = 3'd3,
    ERR_ORDER_COUNT  = 3'd4,
    ERR_TRUNCATED    = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CTRL   = 3'd1,
    PH_WORD   = 3'd2,
    PH_OCOUNT = 3'd3,
    PH_OID    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [18:0] first_word;
    logic [19:0] run_length;
    logic [31:0] word_value;
    logic [31:0] value;
    err_t        error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [TRI_W-1:0] t_eff;
    logic [NW_W-1:0]  nw;
    logic [31:0]      mask;
    logic             order_present;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            vld;
    out_item_t [1:0]       item;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/rle_bitset_record_decoder_core.sv =====
// Top level of the run-length bitset record decoder.
// Depends on rbd_pkg, rbd_cfg, rbd_parser and rbd_out_fifo.
//
//  channel | dir | handshake             | payload
//  rec     | in  | rec_valid / rec_ready | rec (data_byte, record_start)
//  res     | out | res_valid / res_ready | res (kind .. last)
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while rec_ready is high, parsed in the cycle taken.
// Results wait in a four-entry queue, leaving one per cycle with res_ready.
// rec_ready drops while fewer than two queue entries are free.
// A byte that yields two results takes two queue entries.
// Reset clears parser and queue; tri_count resets to 1, order_present to 0.
`default_nettype none

module rle_bitset_record_decoder_core #(
  parameter int TRI_COUNT_BITS = rbd_pkg::TRI_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rec_valid,
  output logic                           rec_ready,
  input  rbd_pkg::in_item_t              rec,
  output logic                           res_valid,
  input  logic                           res_ready,
  output rbd_pkg::out_item_t             res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::TRI_W-1:0]      cfg_data
);
  import rbd_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  space_ok;

  assign rec_ready = space_ok;

  rbd_cfg #(
    .TRI_COUNT_BITS(TRI_COUNT_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  rbd_parser u_parser (
    .clk (clk),
    .rst (rst),
    .fire(rec_valid && rec_ready),
    .item(rec),
    .cfg (cfg),
    .push(push)
  );

  rbd_out_fifo #(
    .DEPTH(OUT_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

endmodule

`default_nettype wire

// ===== rtl/rbd_cfg.sv =====
// Configuration registers; stores the clamped triangle count, word count
// and final word mask at write time. Depends on rbd_pkg.
`default_nettype none

module rbd_cfg #(
  parameter int TRI_COUNT_BITS = rbd_pkg::TRI_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::TRI_W-1:0]      cfg_data,
  output rbd_pkg::cfg_t                  cfg
);
  import rbd_pkg::*;

  localparam logic [31:0] CAP = 32'd1 << TRI_COUNT_BITS;

  logic [TRI_W-1:0] t_new;
  logic [TRI_W:0]   t_round;
  logic [4:0]       rem;
  logic [31:0]      mask_new;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == '0) begin
      t_new = TRI_W'(1);
    end else if (32'(cfg_data) > CAP) begin
      t_new = CAP[TRI_W-1:0];
    end else begin
      t_new = cfg_data;
    end
    t_round  = {1'b0, t_new} + (TRI_W+1)'(31);
    rem      = t_new[4:0];
    mask_new = (rem == 5'd0) ? 32'hFFFF_FFFF : ((32'd1 << rem) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.t_eff         <= TRI_W'(1);
      cfg.nw            <= NW_W'(1);
      cfg.mask          <= 32'd1;
      cfg.order_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TRI_COUNT: begin
          cfg.t_eff <= t_new;
          cfg.nw    <= t_round[TRI_W:5];
          cfg.mask  <= mask_new;
        end
        CFG_ORDER_PRESENT: cfg.order_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rbd_parser.sv =====
// Record parser: varint control words, little-endian words and order stream.
// Emits up to two results per byte. Depends on rbd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rbd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  rbd_pkg::in_item_t   item,
  input  rbd_pkg::cfg_t       cfg,
  output rbd_pkg::push_t      push
);
  import rbd_pkg::*;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] acc;
    logic [2:0]  vbytes;
    logic [19:0] words_done;
    logic [20:0] run_left;
    logic        run_repeated;
    logic [1:0]  wbi;
    logic [23:0] partial;
    logic [24:0] order_left;
  } parse_state_t;

  parse_state_t st, st_next;

  function automatic parse_state_t clear_state();
    parse_state_t r;
    r.phase        = PH_IDLE;
    r.acc          = '0;
    r.vbytes       = '0;
    r.words_done   = '0;
    r.run_left     = '0;
    r.run_repeated = 1'b0;
    r.wbi          = '0;
    r.partial      = '0;
    r.order_left   = '0;
    return r;
  endfunction

  function automatic out_item_t mk(kind_t k, logic [18:0] fw, logic [19:0] rl,
                                   logic [31:0] wv, logic [31:0] val, err_t ec,
                                   logic lst);
    out_item_t r;
    r.kind       = k;
    r.first_word = fw;
    r.run_length = rl;
    r.word_value = wv;
    r.value      = val;
    r.error_code = ec;
    r.last       = lst;
    return r;
  endfunction

  always_comb begin
    parse_state_t s;
    logic         slot;
    logic [31:0]  shifted;
    logic [31:0]  acc_new;
    logic [31:0]  v;
    logic [30:0]  len31;
    logic [31:0]  span;
    logic [31:0]  w;
    logic [19:0]  wd_new;
    logic [19:0]  rl_dec;
    logic [20:0]  fw_end;
    logic [24:0]  ol_dec;
    logic         fin_last;
    s        = st;
    slot     = 1'b0;
    push     = '0;
    shifted  = '0;
    acc_new  = '0;
    v        = '0;
    len31    = '0;
    span     = '0;
    w        = '0;
    wd_new   = '0;
    rl_dec   = '0;
    fw_end   = '0;
    ol_dec   = '0;
    fin_last = 1'b0;
    if (fire) begin
      if (item.record_start) begin
        if (s.phase != PH_IDLE) begin
          push.vld[0]  = 1'b1;
          push.item[0] = mk(KIND_ERROR, '0, '0, '0, '0, ERR_TRUNCATED, 1'b1);
          slot         = 1'b1;
        end
        s       = clear_state();
        s.phase = PH_CTRL;
      end
      unique case (s.phase)
        PH_CTRL, PH_OCOUNT, PH_OID: begin
          case (s.vbytes)
            3'd0:    shifted = 32'(item.data_byte[6:0]);
            3'd1:    shifted = 32'(item.data_byte[6:0]) << 7;
            3'd2:    shifted = 32'(item.data_byte[6:0]) << 14;
            3'd3:    shifted = 32'(item.data_byte[6:0]) << 21;
            3'd4:    shifted = 32'(item.data_byte[6:0]) << 28;
            default: shifted = '0;
          endcase
          acc_new = s.acc | shifted;
          if (item.data_byte[7]) begin
            if (s.vbytes >= 3'd4) begin
              push.vld[slot]  = 1'b1;
              push.item[slot] = mk(KIND_ERROR, '0, '0, '0, '0, ERR_LONG_VARINT, 1'b1);
              s               = clear_state();
            end else begin
              s.acc    = acc_new;
              s.vbytes = s.vbytes + 3'd1;
            end
          end else begin
            v        = acc_new;
            s.acc    = '0;
            s.vbytes = '0;
            len31    = v[31:1];
            span     = 32'(s.words_done) + 32'(len31);
            ol_dec   = s.order_left - 25'd1;
            if (s.phase == PH_CTRL) begin
              if (len31 == '0) begin
                push.vld[slot]  = 1'b1;
                push.item[slot] = mk(KIND_ERROR, '0, '0, '0, '0, ERR_ZERO_RUN, 1'b1);
                s               = clear_state();
              end else if (span > 32'(cfg.nw)) begin
                push.vld[slot]  = 1'b1;
                push.item[slot] = mk(KIND_ERROR, '0, '0, '0, '0, ERR_RUN_OVERFLOW, 1'b1);
                s               = clear_state();
              end else begin
                s.run_left     = len31[20:0];
                s.run_repeated = v[0];
                s.wbi          = '0;
                s.partial      = '0;
                s.phase        = PH_WORD;
              end
            end else if (s.phase == PH_OCOUNT) begin
              if (v > 32'(cfg.t_eff)) begin
                push.vld[slot]  = 1'b1;
                push.item[slot] = mk(KIND_ERROR, '0, '0, '0, '0, ERR_ORDER_COUNT, 1'b1);
                s               = clear_state();
              end else if (v == '0) begin
                push.vld[slot]  = 1'b1;
                push.item[slot] = mk(KIND_COUNT, '0, '0, '0, '0, ERR_NONE, 1'b1);
                s               = clear_state();
              end else begin
                push.vld[slot]  = 1'b1;
                push.item[slot] = mk(KIND_COUNT, '0, '0, '0, v, ERR_NONE, 1'b0);
                s.order_left    = v[24:0];
                s.phase         = PH_OID;
              end
            end else begin
              push.vld[slot] = 1'b1;
              if (ol_dec == '0) begin
                push.item[slot] = mk(KIND_ID, '0, '0, '0, v, ERR_NONE, 1'b1);
                s               = clear_state();
              end else begin
                push.item[slot] = mk(KIND_ID, '0, '0, '0, v, ERR_NONE, 1'b0);
                s.order_left    = ol_dec;
              end
            end
          end
        end
        PH_WORD: begin
          if (s.wbi != 2'd3) begin
            case (s.wbi)
              2'd0:    s.partial[7:0]   = item.data_byte;
              2'd1:    s.partial[15:8]  = item.data_byte;
              default: s.partial[23:16] = item.data_byte;
            endcase
            s.wbi = s.wbi + 2'd1;
          end else begin
            w         = {item.data_byte, s.partial};
            s.partial = '0;
            s.wbi     = '0;
            fin_last  = !cfg.order_present;
            if (s.run_repeated) begin
              wd_new = s.words_done + s.run_left[19:0];
              fw_end = 21'(s.words_done) + s.run_left - 21'd1;
              if ({1'b0, wd_new} >= cfg.nw) begin
                if (s.run_left >= 21'd2) begin
                  push.vld        = 2'b11;
                  push.item[0]    = mk(KIND_RUN, s.words_done[18:0], fw_end[19:0] -
                                       s.words_done, w, '0, ERR_NONE, 1'b0);
                  push.item[1]    = mk(KIND_RUN, fw_end[18:0], 20'd1, w & cfg.mask, '0,
                                       ERR_NONE, fin_last);
                end else begin
                  push.vld[0]     = 1'b1;
                  push.item[0]    = mk(KIND_RUN, s.words_done[18:0], 20'd1, w & cfg.mask,
                                       '0, ERR_NONE, fin_last);
                end
                if (cfg.order_present) begin
                  s.words_done = wd_new;
                  s.run_left   = '0;
                  s.phase      = PH_OCOUNT;
                end else begin
                  s = clear_state();
                end
              end else begin
                push.vld[0]  = 1'b1;
                push.item[0] = mk(KIND_RUN, s.words_done[18:0], s.run_left[19:0], w, '0,
                                  ERR_NONE, 1'b0);
                s.words_done = wd_new;
                s.run_left   = '0;
                s.phase      = PH_CTRL;
              end
            end else begin
              wd_new = s.words_done + 20'd1;
              rl_dec = s.run_left[19:0] - 20'd1;
              push.vld[0] = 1'b1;
              if ({1'b0, wd_new} >= cfg.nw) begin
                push.item[0] = mk(KIND_RUN, s.words_done[18:0], 20'd1, w & cfg.mask, '0,
                                  ERR_NONE, fin_last);
                if (cfg.order_present) begin
                  s.words_done = wd_new;
                  s.run_left   = 21'(rl_dec);
                  s.phase      = PH_OCOUNT;
                end else begin
                  s = clear_state();
                end
              end else begin
                push.item[0] = mk(KIND_RUN, s.words_done[18:0], 20'd1, w, '0,
                                  ERR_NONE, 1'b0);
                s.words_done = wd_new;
                s.run_left   = 21'(rl_dec);
                if (rl_dec == '0) begin
                  s.phase = PH_CTRL;
                end
              end
            end
          end
        end
        PH_IDLE: ;
        default: s = clear_state();
      endcase
    end
    st_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= clear_state();
    end else begin
      st <= st_next;
    end
  end

  `RBD_CHECK_IMPL(a_pair_order, clk, rst, push.vld[1], push.vld[0], "second result without first")
  `RBD_CHECK_IMPL(a_err_last, clk, rst, push.vld[0] && push.item[0].kind == KIND_ERROR, push.item[0].last, "error result without last")
  `RBD_CHECK_IMPL(a_idle_clean, clk, rst, st.phase == PH_IDLE, st.words_done == '0 && st.vbytes == '0 && st.order_left == '0, "idle with stale state")
  `RBD_CHECK_IMPL(a_oid_left, clk, rst, st.phase == PH_OID, st.order_left != '0, "order ids pending with zero count")

endmodule

`default_nettype wire

// ===== rtl/rbd_out_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one per item.
// Depends on rbd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rbd_out_fifo #(
  parameter int DEPTH = rbd_pkg::OUT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  rbd_pkg::push_t      push,
  output logic                space_ok,
  output logic                res_valid,
  input  logic                res_ready,
  output rbd_pkg::out_item_t  res
);
  import rbd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [1:0]         n_wr;
  logic               rd;

  assign n_wr      = {1'b0, push.vld[0]} + {1'b0, push.vld[1]};
  assign res_valid = (count != '0);
  assign rd        = res_valid && res_ready;
  assign res       = mem[rd_ptr];
  assign space_ok  = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.vld[0]) begin
      mem[wr_ptr] <= push.item[0];
    end
    if (push.vld[1]) begin
      mem[PTR_W'(wr_ptr + PTR_W'(1))] <= push.item[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_wr);
      if (rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(n_wr) - CNT_W'(rd);
    end
  end

  `RBD_CHECK(a_cnt_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count above depth")
  `RBD_CHECK_IMPL(a_room, clk, rst, push.vld[0], count <= CNT_W'(DEPTH - 2), "write without room for two")
  `RBD_CHECK_NEXT(a_drain, clk, rst, rd && push.vld == 2'b00, count == $past(count) - CNT_W'(1), "read did not lower count")

endmodule

`default_nettype wire

// ===== tb/tb_rle_bitset_record_decoder_core.sv =====
// Testbench for rle_bitset_record_decoder_core: directed records, then random records under
// changing tri_count/order_present settings, checked against a built-in decoder model.
// Depends on rbd_pkg and the rle_bitset_record_decoder_core RTL.
`default_nettype none

module tb_rle_bitset_record_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rbd_pkg::*;

  localparam int          LIMIT_CYCLES = 1_000_000;
  localparam int          RAND_ITEMS   = 520;
  localparam int          SETTLE       = 8;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;
  localparam logic [24:0] TRI_CAP      = 25'd1 << TRI_COUNT_BITS_DEF;

  logic clk = 1'b0;
  logic rst;
  logic rec_valid, rec_ready;
  in_item_t rec;
  logic res_valid, res_ready;
  out_item_t res;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TRI_W-1:0] cfg_data;

  rle_bitset_record_decoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // decoder model state
  logic [24:0] cfg_tri   = 25'd1;
  logic        cfg_order = 1'b0;
  phase_t      ph        = PH_IDLE;
  logic [31:0] acc       = '0;
  logic [2:0]  vbytes    = '0;
  logic [19:0] done_words = '0;
  logic [19:0] left_words = '0;
  logic        rep       = 1'b0;
  logic [1:0]  bidx      = '0;
  logic [23:0] partial   = '0;
  logic [24:0] ids_left  = '0;
  out_item_t   exp_results[$];

  int mismatches = 0;
  int results_checked = 0;
  int error_reports = 0;
  int bytes_total = 0;
  int rand_bytes = 0;
  int cfg_writes = 0;
  int phase_cnt = 0;
  int send_mode = 1;
  int recv_mode = 1;

  in_item_t pend_q[$];
  in_item_t carry_q[$];
  logic start_next = 1'b0;

  function automatic logic [24:0] eff_tri();
    logic [24:0] t;
    t = (cfg_tri == 25'd0) ? 25'd1 : cfg_tri;
    if (t > TRI_CAP) t = TRI_CAP;
    return t;
  endfunction

  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 16);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  task automatic clear_parser();
    ph = PH_IDLE;
    acc = '0;
    vbytes = '0;
    done_words = '0;
    left_words = '0;
    rep = 1'b0;
    bidx = '0;
    partial = '0;
    ids_left = '0;
  endtask

  task automatic emit(kind_t k, logic [18:0] fw, logic [19:0] rl, logic [31:0] wv,
                      logic [31:0] val, err_t ec, logic lst);
    out_item_t o;
    o.kind = k;
    o.first_word = fw;
    o.run_length = rl;
    o.word_value = wv;
    o.value = val;
    o.error_code = ec;
    o.last = lst;
    exp_results.insert(exp_results.size(), o);
  endtask

  task automatic abort(err_t ec);
    emit(KIND_ERROR, '0, '0, '0, '0, ec, 1'b1);
    clear_parser();
  endtask

  task automatic finish_words(output logic lst);
    if (cfg_order) begin
      ph = PH_OCOUNT;
      lst = 1'b0;
    end else begin
      clear_parser();
      lst = 1'b1;
    end
  endtask

  task automatic decode_byte(in_item_t it);
    logic [7:0]  b;
    logic [24:0] t;
    logic [20:0] nw;
    logic [31:0] mask, v, w, grp;
    logic [19:0] start, len;
    logic        lst;
    b = it.data_byte;
    t = eff_tri();
    nw = 21'((26'(t) + 26'd31) >> 5);
    mask = (t[4:0] != 5'd0) ? ((32'd1 << t[4:0]) - 32'd1) : '1;
    if (it.record_start) begin
      if (ph != PH_IDLE) abort(ERR_TRUNCATED);
      clear_parser();
      ph = PH_CTRL;
    end
    if (ph == PH_CTRL || ph == PH_OCOUNT || ph == PH_OID) begin
      grp = {25'd0, b[6:0]};
      acc = acc | (grp << (7 * int'(vbytes)));
      if (b[7]) begin
        if (vbytes >= 3'd4) abort(ERR_LONG_VARINT);
        else vbytes = vbytes + 3'd1;
        return;
      end
      v = acc;
      acc = '0;
      vbytes = '0;
      case (ph)
        PH_CTRL: begin
          if (v[31:1] == 31'd0) abort(ERR_ZERO_RUN);
          else if (33'(done_words) + 33'(v[31:1]) > 33'(nw)) abort(ERR_RUN_OVERFLOW);
          else begin
            left_words = v[20:1];
            rep = v[0];
            bidx = '0;
            partial = '0;
            ph = PH_WORD;
          end
        end
        PH_OCOUNT: begin
          if (v > 32'(t)) abort(ERR_ORDER_COUNT);
          else if (v == 32'd0) begin
            emit(KIND_COUNT, '0, '0, '0, '0, ERR_NONE, 1'b1);
            clear_parser();
          end else begin
            emit(KIND_COUNT, '0, '0, '0, v, ERR_NONE, 1'b0);
            ids_left = v[24:0];
            ph = PH_OID;
          end
        end
        default: begin
          ids_left = ids_left - 25'd1;
          if (ids_left == 25'd0) begin
            emit(KIND_ID, '0, '0, '0, v, ERR_NONE, 1'b1);
            clear_parser();
          end else begin
            emit(KIND_ID, '0, '0, '0, v, ERR_NONE, 1'b0);
          end
        end
      endcase
      return;
    end
    if (ph == PH_WORD) begin
      if (bidx != 2'd3) begin
        partial = partial | (24'(b) << (8 * int'(bidx)));
        bidx = bidx + 2'd1;
        return;
      end
      w = {b, partial};
      partial = '0;
      bidx = '0;
      start = done_words;
      if (rep) begin
        len = left_words;
        done_words = done_words + len;
        left_words = '0;
        if (21'(done_words) >= nw) begin
          finish_words(lst);
          if (len >= 20'd2) begin
            emit(KIND_RUN, 19'(start), len - 20'd1, w, '0, ERR_NONE, 1'b0);
            emit(KIND_RUN, 19'(start + len - 20'd1), 20'd1, w & mask, '0, ERR_NONE, lst);
          end else begin
            emit(KIND_RUN, 19'(start), 20'd1, w & mask, '0, ERR_NONE, lst);
          end
        end else begin
          ph = PH_CTRL;
          emit(KIND_RUN, 19'(start), len, w, '0, ERR_NONE, 1'b0);
        end
      end else begin
        done_words = done_words + 20'd1;
        left_words = left_words - 20'd1;
        if (21'(done_words) >= nw) begin
          finish_words(lst);
          emit(KIND_RUN, 19'(start), 20'd1, w & mask, '0, ERR_NONE, lst);
        end else begin
          if (left_words == 20'd0) ph = PH_CTRL;
          emit(KIND_RUN, 19'(start), 20'd1, w, '0, ERR_NONE, 1'b0);
        end
      end
    end
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst) begin
      if (rec_valid && rec_ready) decode_byte(rec);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TRI_COUNT) cfg_tri = cfg_data;
        else if (cfg_index == CFG_ORDER_PRESENT) cfg_order = cfg_data[0];
      end
      if (res_valid && res_ready) begin
        if (exp_results.size() == 0) begin
          $error("result with nothing expected: kind %0d value 0x%0h", res.kind, res.value);
          mismatches++;
        end else begin
          want = exp_results.pop_front();
          cmp_field("kind", 32'(want.kind), 32'(res.kind));
          cmp_field("first_word", 32'(want.first_word), 32'(res.first_word));
          cmp_field("run_length", 32'(want.run_length), 32'(res.run_length));
          cmp_field("word_value", want.word_value, res.word_value);
          cmp_field("value", want.value, res.value);
          cmp_field("error_code", 32'(want.error_code), 32'(res.error_code));
          cmp_field("last", 32'(want.last), 32'(res.last));
          results_checked++;
          if (want.kind == KIND_ERROR) error_reports++;
        end
      end
    end
  end

  initial begin : receiver
    int gap;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = draw_gap(recv_mode);
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL rle_bitset_record_decoder_core");
    $finish;
  end

  task automatic send_byte(in_item_t it);
    int gap;
    gap = draw_gap(send_mode);
    @(negedge clk);
    if (gap > 0) begin
      rec_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rec <= it;
    rec_valid <= 1'b1;
    do @(posedge clk); while (!rec_ready);
    bytes_total++;
  endtask

  task automatic send_pending(bit counted);
    while (pend_q.size() != 0) begin
      send_byte(pend_q.pop_front());
      if (counted) rand_bytes++;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    rec_valid <= 1'b0;
    while (exp_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TRI_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic add_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.record_start = start_next;
    pend_q.insert(pend_q.size(), it);
    start_next = 1'b0;
  endtask

  task automatic add_varint(logic [31:0] v, bit pad);
    int n, m, i;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 32'd0) n++;
    m = pad ? $urandom_range(n, 5) : n;
    for (i = 0; i < m; i++) add_byte({(i < m - 1) ? 1'b1 : 1'b0, 7'(v >> (7 * i))});
  endtask

  task automatic add_word(logic [31:0] w);
    add_byte(w[7:0]);
    add_byte(w[15:8]);
    add_byte(w[23:16]);
    add_byte(w[31:24]);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic build_record();
    int nw_i, done, rem_w, len, cap, runs, fault, fault_at, k;
    logic [24:0] t;
    logic [31:0] cnt, id;
    bit rp;
    t = eff_tri();
    nw_i = (int'(t) + 31) / 32;
    fault = $urandom_range(0, 11);
    fault_at = $urandom_range(0, 2);
    start_next = 1'b1;
    done = 0;
    runs = 0;
    while (done < nw_i) begin
      rem_w = nw_i - done;
      if (runs == fault_at && fault >= 8 && fault <= 10) begin
        case (fault)
          8: add_varint({31'd0, 1'($urandom)}, 1'($urandom_range(0, 1)));
          9: begin
            len = $urandom_range(0, 1) ? rem_w + $urandom_range(1, 3)
                                       : $urandom_range(rem_w + 1, 32'h7FFF_FFFF);
            add_varint({len[30:0], 1'($urandom)}, 1'b0);
          end
          default: repeat (5) add_byte(8'($urandom) | 8'h80);
        endcase
        return;
      end
      cap = (rem_w > 8 && $urandom_range(0, 1)) ? rem_w : ((rem_w < 8) ? rem_w : 8);
      len = (runs >= 3) ? rem_w : $urandom_range(1, cap);
      rp = (len > 3) ? 1'b1 : 1'($urandom);
      add_varint({len[30:0], rp}, $urandom_range(0, 3) == 0);
      if (rp) add_word(rand_word());
      else repeat (len) add_word(rand_word());
      done += len;
      runs++;
    end
    if (cfg_order) begin
      case ($urandom_range(0, 9))
        0: cnt = 32'd0;
        1: cnt = 32'(t) + 32'd1;
        2: cnt = $urandom_range(32'(t) + 1, 32'hFFFF_FFFF);
        3: cnt = (t <= 25'd6) ? 32'(t) : 32'd6;
        default: cnt = $urandom_range(1, (t < 25'd6) ? 32'(t) : 6);
      endcase
      add_varint(cnt, $urandom_range(0, 3) == 0);
      if (cnt <= 32'(t)) begin
        for (k = 0; k < int'(cnt); k++) begin
          if (fault == 11 && k == 0) begin
            repeat (5) add_byte(8'($urandom) | 8'h80);
          end else if ($urandom_range(0, 7) == 0) begin
            repeat (4) add_byte(8'($urandom) | 8'h80);
            add_byte(8'($urandom) & 8'h7F);
          end else begin
            case ($urandom_range(0, 2))
              0: id = $urandom_range(0, 127);
              1: id = $urandom;
              default: id = $urandom_range(0, 32'(t));
            endcase
            add_varint(id, $urandom_range(0, 3) == 0);
          end
        end
      end
    end
  endtask

  task automatic test_defaults();
    start_next = 1'b1;
    add_byte(8'h03);
    add_word(32'hFFFF_FFFF);
    add_byte(8'hAA);
    start_next = 1'b1;
    add_byte(8'h01);
    start_next = 1'b1;
    add_byte(8'h05);
    start_next = 1'b1;
    repeat (5) add_byte(8'h80);
    start_next = 1'b1;
    add_byte(8'h03);
    add_byte(8'h12);
    start_next = 1'b1;
    add_byte(8'h03);
    add_word(32'h0000_0000);
    send_pending(1'b0);
    drain();
  endtask

  task automatic test_order_stream();
    write_reg(CFG_TRI_COUNT, 25'd40);
    write_reg(CFG_ORDER_PRESENT, 25'd1);
    start_next = 1'b1;
    add_byte(8'h05);
    add_word(32'hDEAD_BEEF);
    add_byte(8'h02);
    repeat (4) add_byte(8'hFF);
    add_byte(8'h7F);
    add_byte(8'h00);
    start_next = 1'b1;
    add_byte(8'h04);
    add_word(32'h1234_5678);
    add_word(32'h8000_0001);
    add_byte(8'h29);
    start_next = 1'b1;
    add_byte(8'h05);
    add_word(32'h5A5A_A5A5);
    add_byte(8'h00);
    send_pending(1'b0);
    drain();
  endtask

  task automatic test_tri_extremes();
    write_reg(CFG_TRI_COUNT, 25'd0);
    write_reg(CFG_ORDER_PRESENT, 25'd0);
    start_next = 1'b1;
    add_byte(8'h03);
    add_word(32'hFFFF_FFFE);
    send_pending(1'b0);
    drain();
    write_reg(CFG_TRI_COUNT, 25'h1FF_FFFF);
    start_next = 1'b1;
    add_varint(32'h0010_0001, 1'b0);
    add_word(32'hC3C3_3C3C);
    send_pending(1'b0);
    drain();
    write_reg(CFG_TRI_COUNT, 25'h100_0000);
    write_reg(CFG_ORDER_PRESENT, 25'd1);
    start_next = 1'b1;
    add_varint(32'h0010_0001, 1'b0);
    add_word(32'hFFFF_FFFF);
    add_varint(32'h0100_0001, 1'b0);
    send_pending(1'b0);
    drain();
  endtask

  task automatic test_mid_record();
    write_reg(CFG_TRI_COUNT, 25'd64);
    write_reg(CFG_ORDER_PRESENT, 25'd0);
    start_next = 1'b1;
    add_byte(8'h03);
    add_word(32'h0F0F_0F0F);
    send_pending(1'b0);
    drain();
    write_reg(CFG_TRI_COUNT, 25'd32);
    add_byte(8'h03);
    send_pending(1'b0);
    drain();
    write_reg(CFG_TRI_COUNT, 25'd33);
    start_next = 1'b1;
    add_byte(8'h03);
    add_word(32'h1111_2222);
    add_byte(8'h03);
    add_byte(8'hAB);
    add_byte(8'hCD);
    send_pending(1'b0);
    drain();
    write_reg(CFG_TRI_COUNT, 25'd64);
    add_byte(8'hEF);
    add_byte(8'hFE);
    send_pending(1'b0);
    drain();
  endtask

  task automatic test_random();
    int nrec, i, k;
    logic [24:0] tri_val, d;
    while (rand_bytes < RAND_ITEMS) begin
      drain();
      case (phase_cnt % 12)
        0: tri_val = 25'd0;
        1: tri_val = 25'd1;
        2: tri_val = 25'd33;
        3: tri_val = 25'($urandom_range(2, 100));
        4: tri_val = 25'h1FF_FFFF;
        5: tri_val = 25'd32;
        6: tri_val = 25'($urandom_range(100, 3000));
        7: tri_val = 25'h100_0000;
        8: tri_val = 25'd31;
        9: tri_val = 25'($urandom_range(1, 32'h1FF_FFFF));
        10: tri_val = 25'd65;
        default: tri_val = 25'($urandom_range(2, 64));
      endcase
      if (phase_cnt < 2 || $urandom_range(0, 3) != 0) write_reg(CFG_TRI_COUNT, tri_val);
      if (phase_cnt < 2 || $urandom_range(0, 1)) begin
        d = 25'($urandom);
        d[0] = (phase_cnt == 0) ? 1'b1 : (phase_cnt == 1) ? 1'b0 : 1'($urandom);
        write_reg(CFG_ORDER_PRESENT, d);
      end
      if (phase_cnt == 3) write_reg(CFG_UNUSED, 25'($urandom));
      send_mode = $urandom_range(0, 2);
      recv_mode = $urandom_range(0, 2);
      while (carry_q.size() != 0) pend_q.insert(pend_q.size(), carry_q.pop_front());
      send_pending(1'b1);
      nrec = $urandom_range(3, 8);
      for (i = 0; i < nrec; i++) begin
        build_record();
        if (i == nrec - 1 && pend_q.size() > 1 && $urandom_range(0, 2) == 0) begin
          k = $urandom_range(1, pend_q.size() - 1);
          while (pend_q.size() > k) carry_q.push_front(pend_q.pop_back());
        end else if (pend_q.size() > 1 && $urandom_range(0, 7) == 0) begin
          k = $urandom_range(1, pend_q.size() - 1);
          while (pend_q.size() > k) void'(pend_q.pop_back());
        end
        send_pending(1'b1);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
          send_pending(1'b0);
        end
      end
      phase_cnt++;
    end
    drain();
    while (carry_q.size() != 0) pend_q.insert(pend_q.size(), carry_q.pop_front());
    send_pending(1'b1);
  endtask

  initial begin
    rst = 1'b1;
    rec_valid = 1'b0;
    rec = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_order_stream();
    test_tri_extremes();
    test_mid_record();
    test_random();
    drain();
    repeat (16) @(negedge clk);
    $display("Sent %0d record bytes (%0d in random records) over %0d random setting phases",
             bytes_total, rand_bytes, phase_cnt);
    $display("with %0d register writes; checked %0d results, %0d of them error reports",
             cfg_writes, results_checked, error_reports);
    if (mismatches == 0) begin
      $display("PASS rle_bitset_record_decoder_core");
    end else begin
      $display("FAIL rle_bitset_record_decoder_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
